// ----- hw/rtl/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and helpers for the byte ring FIFO with run counters.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 15;
  localparam int unsigned CNT_W  = 32;

  localparam int unsigned RESERVE       = 2048;
  localparam int unsigned MIN_SIZE      = 2 * RESERVE;
  localparam int unsigned DEF_MAX_DEPTH = 16384;
  localparam logic [FILL_W-1:0] SIZE_RESET = 15'd16384;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] wr_data;
    logic              burst_last;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd_data;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_level;
    logic [CNT_W-1:0]  overrun_count;
    logic [CNT_W-1:0]  underrun_count;
    logic              last;
  } out_item_t;

  // per-item result from the control logic; byte comes later from the store
  typedef struct packed {
    logic              rd_hit;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  ovr;
    logic [CNT_W-1:0]  und;
    logic              last;
  } step_t;

  // slots in use: configured size limited to [MIN_SIZE, max_depth]
  function automatic logic [FILL_W-1:0] size_clamp(input logic [FILL_W-1:0] v,
                                                   input int unsigned max_depth);
    logic [FILL_W-1:0] r;
    if (32'(v) < MIN_SIZE) begin
      r = FILL_W'(MIN_SIZE);
    end else if (32'(v) > max_depth) begin
      r = FILL_W'(max_depth);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/byte_ring_fifo_with_run_counters.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_run_counters
// Byte ring FIFO with configurable size and overrun/underrun counters.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------
//   in_     | in  | in_valid / in_ready  | in_data  (brf_pkg::in_item_t)
//   out_    | out | out_valid / out_ready| out_data (brf_pkg::out_item_t)
//   cfg_    | in  | cfg_valid / cfg_ready| cfg_data (buffer size, 15 bits)
//
// One request per cycle; each result appears the cycle after its transfer,
// set by the registered read data of the byte store.
// Output register stalls the input only while a result is held.
// Reset (rst_n low, synchronous) empties the ring, clears the counters and
// sets the size to 16384 slots; no clearing pass over the store.
// cfg_ready is always high; a size write also empties the ring.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_run_counters #(
  parameter int unsigned MAX_DEPTH = brf_pkg::DEF_MAX_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  brf_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output brf_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brf_pkg::FILL_W-1:0] cfg_data
);

  localparam int unsigned PTR_W = $clog2(MAX_DEPTH);

  logic                       in_fire;
  logic                       out_valid_r;
  brf_pkg::step_t             res, res_r;
  logic                       mem_we, mem_re;
  logic [PTR_W-1:0]           mem_waddr, mem_raddr;
  logic [brf_pkg::DATA_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  brf_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .PTR_W     (PTR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_size  (cfg_data),
    .step      (in_fire),
    .item      (in_data),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  brf_store #(
    .MAX_DEPTH (MAX_DEPTH),
    .PTR_W     (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data.wr_data),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register; store read data is aligned with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_data.rd_data        = res_r.rd_hit ? mem_rdata : '0;
  assign out_data.status         = res_r.status;
  assign out_data.fill_level     = res_r.fill;
  assign out_data.overrun_count  = res_r.ovr;
  assign out_data.underrun_count = res_r.und;
  assign out_data.last           = res_r.last;

`ifndef SYNTH
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == brf_pkg::ST_EMPTY |-> out_data.fill_level == '0)
    else $error("read refused with bytes held");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == brf_pkg::ST_FULL
      |-> 32'(out_data.fill_level) >= brf_pkg::MIN_SIZE)
    else $error("write refused below minimum size");

  a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != brf_pkg::ST_DONE |-> out_data.rd_data == '0)
    else $error("refused request returned data");

  a_store_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we || mem_re) |-> in_fire && !(mem_we && mem_re))
    else $error("store access without a request transfer");
`endif

endmodule

// ----- hw/rtl/brf_store.sv -----
// ----------------------------------------------------------------------------
// brf_store
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brf_store #(
  parameter int unsigned MAX_DEPTH = brf_pkg::DEF_MAX_DEPTH,
  parameter int unsigned PTR_W     = $clog2(MAX_DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [PTR_W-1:0]           waddr,
  input  logic [brf_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [PTR_W-1:0]           raddr,
  output logic [brf_pkg::DATA_W-1:0] rdata
);

  logic [brf_pkg::DATA_W-1:0] mem [MAX_DEPTH];
  logic [brf_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read so a stalled result keeps its byte
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/brf_ctrl.sv -----
// ----------------------------------------------------------------------------
// brf_ctrl
// Ring pointers, fill level, overrun/underrun counters and size register.
// Issues the store access for each accepted request.
// ----------------------------------------------------------------------------
module brf_ctrl #(
  parameter int unsigned MAX_DEPTH = brf_pkg::DEF_MAX_DEPTH,
  parameter int unsigned PTR_W     = $clog2(MAX_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [brf_pkg::FILL_W-1:0] cfg_size,
  input  logic                       step,
  input  brf_pkg::in_item_t          item,
  output brf_pkg::step_t             res,
  output logic                       mem_we,
  output logic [PTR_W-1:0]           mem_waddr,
  output logic                       mem_re,
  output logic [PTR_W-1:0]           mem_raddr
);

  localparam int unsigned CMP_W =
    (PTR_W + 1 > brf_pkg::FILL_W) ? PTR_W + 1 : brf_pkg::FILL_W;

  logic [PTR_W-1:0]           rp_r, rp_nxt, wp_r, wp_nxt;
  logic [brf_pkg::FILL_W-1:0] fill_r, fill_nxt, size_r;
  logic [brf_pkg::CNT_W-1:0]  ovr_r, ovr_nxt, und_r, und_nxt;
  logic [CMP_W-1:0]           rp_inc, wp_inc;
  logic                       full, empty, wr_ok, rd_ok;
  logic [brf_pkg::STAT_W-1:0] status;

  assign full   = fill_r >= size_r;
  assign empty  = fill_r == '0;
  assign rp_inc = CMP_W'(rp_r) + CMP_W'(1);
  assign wp_inc = CMP_W'(wp_r) + CMP_W'(1);

  always_comb begin
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    ovr_nxt  = ovr_r;
    und_nxt  = und_r;
    status   = brf_pkg::ST_DONE;
    wr_ok    = 1'b0;
    rd_ok    = 1'b0;
    case (item.req_type)
      brf_pkg::REQ_WRITE: begin
        if (full) begin
          ovr_nxt = ovr_r + brf_pkg::CNT_W'(1);
          status  = brf_pkg::ST_FULL;
        end else begin
          wr_ok    = 1'b1;
          wp_nxt   = (wp_inc >= CMP_W'(size_r)) ? '0 : wp_inc[PTR_W-1:0];
          fill_nxt = fill_r + brf_pkg::FILL_W'(1);
        end
      end
      brf_pkg::REQ_READ: begin
        if (empty) begin
          und_nxt = und_r + brf_pkg::CNT_W'(1);
          status  = brf_pkg::ST_EMPTY;
        end else begin
          rd_ok    = 1'b1;
          rp_nxt   = (rp_inc >= CMP_W'(size_r)) ? '0 : rp_inc[PTR_W-1:0];
          fill_nxt = fill_r - brf_pkg::FILL_W'(1);
        end
      end
      brf_pkg::REQ_CLEAR: begin
        rp_nxt   = '0;
        wp_nxt   = '0;
        fill_nxt = '0;
        ovr_nxt  = '0;
        und_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= brf_pkg::size_clamp(brf_pkg::SIZE_RESET, MAX_DEPTH);
      rp_r   <= '0;
      wp_r   <= '0;
      fill_r <= '0;
      ovr_r  <= '0;
      und_r  <= '0;
    end else if (cfg_we) begin
      // size write also empties the ring
      size_r <= brf_pkg::size_clamp(cfg_size, MAX_DEPTH);
      rp_r   <= '0;
      wp_r   <= '0;
      fill_r <= '0;
      ovr_r  <= '0;
      und_r  <= '0;
    end else if (step) begin
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      ovr_r  <= ovr_nxt;
      und_r  <= und_nxt;
    end
  end

  assign mem_we    = step && wr_ok;
  assign mem_waddr = wp_r;
  assign mem_re    = step && rd_ok;
  assign mem_raddr = rp_r;

  assign res.rd_hit = rd_ok;
  assign res.status = status;
  assign res.fill   = fill_nxt;
  assign res.ovr    = ovr_nxt;
  assign res.und    = und_nxt;
  assign res.last   = item.burst_last;

endmodule

// ----- dv/brf_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_result_checker
// Watches the request, result and size channels of the byte ring FIFO, keeps
// its own copy of the ring, pointers and run counters, and compares every
// result transfer field by field against the oldest result still owed.
// ----------------------------------------------------------------------------
module brf_result_checker
  import brf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [FILL_W-1:0] cfg_data,
  output int                owed_count,
  output int                mismatch_count
);

  localparam int unsigned RING_MAX    = DEF_MAX_DEPTH;
  localparam int          MAX_REPORTS = 10;

  logic [DATA_W-1:0] ring_mem [RING_MAX];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       fill;
  logic [CNT_W-1:0]  ovr_total;
  logic [CNT_W-1:0]  und_total;
  logic [FILL_W-1:0] size_reg;
  out_item_t         due_results [$];
  int                n_bad = 0;

  initial begin
    owed_count     = 0;
    mismatch_count = 0;
  end

  function automatic void empty_ring();
    rd_ptr    = 0;
    wr_ptr    = 0;
    fill      = 0;
    ovr_total = '0;
    und_total = '0;
  endfunction

  // configured size held to [MIN_SIZE, RING_MAX]
  function automatic int unsigned slots_active();
    int unsigned s;
    s = size_reg;
    if (s < MIN_SIZE) s = MIN_SIZE;
    if (s > RING_MAX) s = RING_MAX;
    return s;
  endfunction

  function automatic out_item_t ring_access(input in_item_t req);
    out_item_t   r;
    int unsigned slots;
    slots    = slots_active();
    r        = '0;
    r.status = ST_DONE;
    r.last   = req.burst_last;
    case (req.req_type)
      REQ_WRITE: begin
        if (fill >= slots) begin
          ovr_total = ovr_total + 1'b1;
          r.status  = ST_FULL;
        end else begin
          ring_mem[wr_ptr] = req.wr_data;
          wr_ptr = (wr_ptr + 1 >= slots) ? 0 : wr_ptr + 1;
          fill++;
        end
      end
      REQ_READ: begin
        if (fill == 0) begin
          und_total = und_total + 1'b1;
          r.status  = ST_EMPTY;
        end else begin
          r.rd_data = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1 >= slots) ? 0 : rd_ptr + 1;
          fill--;
        end
      end
      REQ_CLEAR: empty_ring();
      default: ;  // unused code leaves everything alone
    endcase
    r.fill_level     = FILL_W'(fill);
    r.overrun_count  = ovr_total;
    r.underrun_count = und_total;
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (got !== want) begin
      n_bad++;
      if (n_bad <= MAX_REPORTS)
        $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      size_reg = SIZE_RESET;
      empty_ring();
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("%0t: result transfer with none due: %p", $time, out_data);
        end else begin
          want = due_results.pop_front();
          compare_field("rd_data", CNT_W'(want.rd_data), CNT_W'(out_data.rd_data));
          compare_field("status", CNT_W'(want.status), CNT_W'(out_data.status));
          compare_field("fill_level", CNT_W'(want.fill_level),
                        CNT_W'(out_data.fill_level));
          compare_field("overrun_count", want.overrun_count, out_data.overrun_count);
          compare_field("underrun_count", want.underrun_count, out_data.underrun_count);
          compare_field("last", CNT_W'(want.last), CNT_W'(out_data.last));
        end
      end
      // a size write also empties the ring
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
        empty_ring();
      end
      if (in_valid && in_ready) due_results.push_back(ring_access(in_data));
    end
    owed_count     <= due_results.size();
    mismatch_count <= n_bad;
  end

endmodule

// ----- dv/tb_byte_ring_fifo_with_run_counters.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_run_counters
// Drives byte writes, reads, clears and the unused request code into the ring
// FIFO under several buffer sizes, in range and out of range, and lets the
// checker judge results.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_run_counters;
  import brf_pkg::*;

  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;  // unused request code
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [FILL_W-1:0] cfg_data = '0;
  logic              no_idle = 1'b0;
  int                owed_count;
  int                mismatch_count;
  int                cycle_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_ring_fifo_with_run_counters u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  brf_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .owed_count     (owed_count),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_byte_ring_fifo_with_run_counters: errors");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off once the ring is filling
  initial begin : result_sink
    int  results_taken;
    bit  hold_done;
    results_taken = 0;
    hold_done     = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) results_taken++;
      if (results_taken == HOLD_AFTER && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 28);
    end
  end

  function automatic in_item_t req_item(input logic [REQ_W-1:0] kind,
                                        input logic [DATA_W-1:0] data,
                                        input logic mark);
    in_item_t it;
    it.req_type   = kind;
    it.wr_data    = data;
    it.burst_last = mark;
    return it;
  endfunction

  task automatic send_item(input in_item_t item);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [FILL_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // bursts of writes or reads marked on their last byte, with some noise
  task automatic random_traffic(input int n_items);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 16);
      if (pick < 90) begin
        for (int i = 0; i < len; i++)
          send_item(req_item(pick < 45 ? REQ_WRITE : REQ_READ, 8'($urandom),
                             i == len - 1));
        sent += len;
      end else begin
        if (pick < 94)
          send_item(req_item(REQ_CLEAR, 8'($urandom), 1'($urandom)));
        else if (pick < 97)
          send_item(req_item(REQ_NOP, 8'($urandom), 1'($urandom)));
        else
          send_item(req_item(REQ_W'($urandom_range(0, 3)), 8'($urandom),
                             1'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at the reset size
    send_item(req_item(REQ_READ, 8'h00, 1'b1));   // read on empty
    send_item(req_item(REQ_NOP, 8'hFF, 1'b0));
    send_item(req_item(REQ_WRITE, 8'h00, 1'b0));
    send_item(req_item(REQ_WRITE, 8'hFF, 1'b1));
    send_item(req_item(REQ_WRITE, 8'hA5, 1'b0));
    send_item(req_item(REQ_READ, 8'hFF, 1'b0));
    send_item(req_item(REQ_READ, 8'h00, 1'b0));
    send_item(req_item(REQ_READ, 8'h5A, 1'b1));
    send_item(req_item(REQ_READ, 8'h00, 1'b0));   // underrun again
    send_item(req_item(REQ_WRITE, 8'h5A, 1'b0));
    send_item(req_item(REQ_NOP, 8'h00, 1'b1));
    send_item(req_item(REQ_READ, 8'h00, 1'b0));
    send_item(req_item(REQ_WRITE, 8'h3C, 1'b0));
    send_item(req_item(REQ_WRITE, 8'hC3, 1'b0));
    send_item(req_item(REQ_CLEAR, 8'h00, 1'b0));  // clear with bytes held
    send_item(req_item(REQ_READ, 8'h00, 1'b1));
    send_item(req_item(REQ_WRITE, 8'h81, 1'b1));
    send_item(req_item(REQ_READ, 8'h7E, 1'b0));
    send_item(req_item(REQ_CLEAR, 8'hFF, 1'b1));
    send_item(req_item(REQ_READ, 8'h00, 1'b0));

    // below range: runs as the minimum size
    drain_results();
    set_size('0);
    random_traffic(210);

    // above range: runs as the maximum size
    drain_results();
    set_size('1);
    random_traffic(210);

    drain_results();
    set_size(FILL_W'(MIN_SIZE));
    no_idle <= 1'b1;
    random_traffic(210);
    no_idle <= 1'b0;

    drain_results();
    set_size(FILL_W'($urandom_range(MIN_SIZE + 1, DEF_MAX_DEPTH - 1)));
    random_traffic(105);
    drain_results();
    random_traffic(105);

    drain_results();
    set_size(FILL_W'($urandom_range(1, MIN_SIZE - 1)));
    random_traffic(210);

    drain_results();
    set_size(FILL_W'(DEF_MAX_DEPTH));
    random_traffic(100);

    drain_results();
    if (mismatch_count == 0)
      $display("tb_byte_ring_fifo_with_run_counters: clean");
    else
      $display("tb_byte_ring_fifo_with_run_counters: errors");
    $finish;
  end

endmodule
